// File: design/pngu_pkg.sv
// package: shared types and constants of the png scanline unfilter
`default_nettype none
package pngu_pkg;

  localparam int MAX_ROW_BYTES = 65536;
  localparam int COL_W         = $clog2(MAX_ROW_BYTES);
  localparam int LEN_W         = 17;
  localparam int BPP_W         = 3;
  localparam int ADDR_W        = 3;
  localparam int DATA_W        = 32;

  localparam logic [BPP_W-1:0] BPP_MAX       = 3'd4;
  localparam logic [LEN_W-1:0] ROW_LEN_MAX   = LEN_W'(MAX_ROW_BYTES);
  localparam logic [7:0]       FILTER_MAX    = 8'd4;

  // register index, taken from paddr[2]
  localparam logic REG_BPP     = 1'b0;
  localparam logic REG_ROW_LEN = 1'b1;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filter_kind_t;

  // clamped configuration as seen by the front end
  typedef struct packed {
    logic [1:0]       bpp_sel;   // bytes per pixel minus one
    logic [LEN_W-1:0] row_len;   // 1 .. MAX_ROW_BYTES
  } cfg_t;

  // one classified byte on its way to the back end
  typedef struct packed {
    logic             is_error;
    logic [7:0]       data_byte;
    filter_kind_t     filter;
    logic [COL_W-1:0] column;
    logic             first;
    logic             last;
    logic             have_above;
    logic [1:0]       bpp_sel;
  } item_t;

endpackage
`default_nettype wire

// File: design/pngu_if.sv
// interfaces: input byte channel and result channel
`default_nettype none
interface pngu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       image_start;

  modport source (output valid, output data_byte, output image_start, input ready);
  modport sink   (input valid, input data_byte, input image_start, output ready);
endinterface

interface pngu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;
  logic       row_end;
  logic       filter_error;

  modport source (output valid, output pixel_byte, output row_end, output filter_error,
                  input ready);
  modport sink   (input valid, input pixel_byte, input row_end, input filter_error,
                  output ready);
endinterface
`default_nettype wire

// File: design/pngu_front.sv
// front end: row tracking, filter byte decode and byte classification
`default_nettype none
module pngu_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  pngu_in_if.sink            in_ch,
  input  wire logic [pngu_pkg::BPP_W-1:0] bpp_raw,
  input  wire logic [pngu_pkg::LEN_W-1:0] row_len_raw,
  output logic               push_valid,
  output pngu_pkg::item_t    push_item,
  input  wire logic          push_ready
);

  pngu_pkg::cfg_t cfg;

  logic                        halted_r, halted_nxt;
  logic                        have_prior_r, have_prior_nxt;
  logic                        awaiting_r, awaiting_nxt;
  logic [pngu_pkg::COL_W-1:0]  column_r, column_nxt;
  pngu_pkg::filter_kind_t      filter_r, filter_nxt;

  logic                        halted_e, have_prior_e, awaiting_e;
  logic [pngu_pkg::COL_W-1:0]  column_e;
  logic                        accept, last;

  // clamp out-of-range register values
  always_comb begin
    if (bpp_raw == '0) begin
      cfg.bpp_sel = 2'd0;
    end else if (bpp_raw > pngu_pkg::BPP_MAX) begin
      cfg.bpp_sel = 2'd3;
    end else begin
      cfg.bpp_sel = 2'(bpp_raw - 3'd1);
    end
    if (row_len_raw == '0) begin
      cfg.row_len = pngu_pkg::LEN_W'(1);
    end else if (row_len_raw > pngu_pkg::ROW_LEN_MAX) begin
      cfg.row_len = pngu_pkg::ROW_LEN_MAX;
    end else begin
      cfg.row_len = row_len_raw;
    end
  end

  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid && push_ready;

  // image start overrides the row state
  assign halted_e     = in_ch.image_start ? 1'b0 : halted_r;
  assign have_prior_e = in_ch.image_start ? 1'b0 : have_prior_r;
  assign awaiting_e   = in_ch.image_start ? 1'b1 : awaiting_r;
  assign column_e     = in_ch.image_start ? '0 : column_r;

  assign last = ({1'b0, column_e} + pngu_pkg::LEN_W'(1)) >= cfg.row_len;

  always_comb begin
    halted_nxt     = halted_e;
    have_prior_nxt = have_prior_e;
    awaiting_nxt   = awaiting_e;
    column_nxt     = column_e;
    filter_nxt     = filter_r;
    push_valid     = 1'b0;

    push_item.is_error   = 1'b0;
    push_item.data_byte  = in_ch.data_byte;
    push_item.filter     = filter_r;
    push_item.column     = column_e;
    push_item.first      = (column_e == '0);
    push_item.last       = last;
    push_item.have_above = have_prior_e;
    push_item.bpp_sel    = cfg.bpp_sel;

    if (!halted_e) begin
      if (awaiting_e) begin
        if (in_ch.data_byte > pngu_pkg::FILTER_MAX) begin
          halted_nxt         = 1'b1;
          push_valid         = in_ch.valid;
          push_item.is_error = 1'b1;
        end else begin
          filter_nxt   = pngu_pkg::filter_kind_t'(in_ch.data_byte[2:0]);
          awaiting_nxt = 1'b0;
          column_nxt   = '0;
        end
      end else begin
        push_valid = in_ch.valid;
        if (last) begin
          have_prior_nxt = 1'b1;
          awaiting_nxt   = 1'b1;
          column_nxt     = '0;
        end else begin
          column_nxt = column_e + pngu_pkg::COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      halted_r     <= 1'b0;
      have_prior_r <= 1'b0;
      awaiting_r   <= 1'b1;
      column_r     <= '0;
      filter_r     <= pngu_pkg::FILT_NONE;
    end else if (accept) begin
      halted_r     <= halted_nxt;
      have_prior_r <= have_prior_nxt;
      awaiting_r   <= awaiting_nxt;
      column_r     <= column_nxt;
      filter_r     <= filter_nxt;
    end
  end

endmodule
`default_nettype wire

// File: design/pngu_queue.sv
// two-entry queue between front and back end
`default_nettype none
module pngu_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  input  wire pngu_pkg::item_t  push_item,
  output logic                  push_ready,
  output logic                  pop_valid,
  output pngu_pkg::item_t       pop_item,
  input  wire logic             pop_ready
);

  pngu_pkg::item_t slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_item   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

// File: design/pngu_back.sv
// back end: line store, predictor and reconstruction, output register
`default_nettype none
module pngu_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             pop_valid,
  input  wire pngu_pkg::item_t  pop_item,
  output logic                  pop_ready,
  pngu_out_if.source            out_ch
);

  function automatic logic [9:0] abs_diff(input logic [9:0] x, input logic [9:0] y);
    return (x >= y) ? (x - y) : (y - x);
  endfunction

  function automatic logic [7:0] pick_byte(input logic [31:0] w, input logic [1:0] sel);
    logic [7:0] b;
    case (sel)
      2'd0:    b = w[7:0];
      2'd1:    b = w[15:8];
      2'd2:    b = w[23:16];
      default: b = w[31:24];
    endcase
    return b;
  endfunction

  logic [7:0] line_mem [pngu_pkg::MAX_ROW_BYTES];
  logic [7:0] rd_data_r;
  logic       byp_r;
  logic [7:0] byp_data_r;

  logic            s1_valid_r;
  pngu_pkg::item_t s1_r;
  logic            s1_adv, rd_en, wr_en;

  logic [31:0] recent_bytes_r, recent_above_r;
  logic [31:0] rb, ra;
  logic [7:0]  above, left, corner, pred, value;
  logic [8:0]  avg_sum;
  logic [9:0]  da, db, dc;

  logic       out_valid_r;
  logic [7:0] out_pixel_r;
  logic       out_row_end_r, out_error_r;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign pop_ready = !s1_valid_r || s1_adv;
  assign rd_en     = pop_valid && pop_ready;
  assign wr_en     = s1_adv && !s1_r.is_error;

  // predictor inputs; recent bytes count as zero at the start of a row
  always_comb begin
    rb     = s1_r.first ? '0 : recent_bytes_r;
    ra     = s1_r.first ? '0 : recent_above_r;
    above  = s1_r.have_above ? (byp_r ? byp_data_r : rd_data_r) : 8'd0;
    left   = pick_byte(rb, s1_r.bpp_sel);
    corner = pick_byte(ra, s1_r.bpp_sel);

    avg_sum = {1'b0, left} + {1'b0, above};
    da = abs_diff({2'b00, above}, {2'b00, corner});
    db = abs_diff({2'b00, left}, {2'b00, corner});
    dc = abs_diff({2'b00, left} + {2'b00, above}, {1'b0, corner, 1'b0});

    case (s1_r.filter)
      pngu_pkg::FILT_SUB: pred = left;
      pngu_pkg::FILT_UP:  pred = above;
      pngu_pkg::FILT_AVG: pred = avg_sum[8:1];
      pngu_pkg::FILT_PAETH: begin
        if (da <= db && da <= dc) begin
          pred = left;
        end else if (db <= dc) begin
          pred = above;
        end else begin
          pred = corner;
        end
      end
      default: pred = 8'd0;
    endcase
    value = s1_r.data_byte + pred;
  end

  // line store, read before write; same-cycle collision forwarded
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[s1_r.column] <= value;
    end
    if (rd_en) begin
      rd_data_r  <= line_mem[pop_item.column];
      byp_r      <= wr_en && (s1_r.column == pop_item.column);
      byp_data_r <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      recent_bytes_r <= '0;
      recent_above_r <= '0;
    end else begin
      if (pop_ready) begin
        s1_valid_r <= pop_valid;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (wr_en) begin
        recent_bytes_r <= {rb[23:0], value};
        recent_above_r <= {ra[23:0], above};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_r <= pop_item;
    end
    if (s1_adv) begin
      out_pixel_r   <= s1_r.is_error ? 8'd0 : value;
      out_row_end_r <= !s1_r.is_error && s1_r.last;
      out_error_r   <= s1_r.is_error;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pixel_byte   = out_pixel_r;
  assign out_ch.row_end      = out_row_end_r;
  assign out_ch.filter_error = out_error_r;

endmodule
`default_nettype wire

// File: design/png_scanline_unfilter_unit.sv
// top level: png scanline unfilter with config registers
//
// in_ch carries the inflated stream, one byte per transfer; image_start marks
// the filter type byte of a new image. out_ch carries one reconstructed byte
// per filtered data byte, with row_end on the last byte of a row, or a single
// filter_error transfer when a filter type above 4 is seen (bytes are then
// dropped until the next image_start). filter type bytes give no transfer.
// throughput is one byte per cycle while out_ch takes every byte, set by the
// left-neighbor loop in the back end (one add plus paeth select per cycle).
// a result passes through the queue slot, then the s1 register alongside the
// line store read, then the output register, where it sits until taken.
// when out_ch stalls, the output register and back end hold, the two-entry
// queue fills and in_ch.ready drops; it rises again once the queue has room.
// reset clears the row state so the first bytes count as the first row of an
// image, and sets bytes_per_pixel and row_length to 1. the line store has no
// reset and needs none: each row reads only columns the row before it wrote.
// registers: bytes_per_pixel at 0x0, row_length at 0x4; write them only
// while no byte is in flight.
`default_nettype none
module png_scanline_unfilter_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  pngu_in_if.sink                           in_ch,
  pngu_out_if.source                        out_ch,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [pngu_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [pngu_pkg::DATA_W-1:0]  pwdata,
  output logic      [pngu_pkg::DATA_W-1:0]  prdata,
  output logic                              pready
);

  logic [pngu_pkg::BPP_W-1:0] bpp_r;
  logic [pngu_pkg::LEN_W-1:0] row_len_r;
  logic                       cfg_wr;

  logic            push_valid, push_ready;
  pngu_pkg::item_t push_item;
  logic            pop_valid, pop_ready;
  pngu_pkg::item_t pop_item;

  // register access, zero wait states
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r     <= pngu_pkg::BPP_W'(1);
      row_len_r <= pngu_pkg::LEN_W'(1);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        pngu_pkg::REG_BPP:     bpp_r     <= pwdata[pngu_pkg::BPP_W-1:0];
        pngu_pkg::REG_ROW_LEN: row_len_r <= pwdata[pngu_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      pngu_pkg::REG_BPP:     prdata = pngu_pkg::DATA_W'(bpp_r);
      pngu_pkg::REG_ROW_LEN: prdata = pngu_pkg::DATA_W'(row_len_r);
      default:               prdata = '0;
    endcase
  end

  // front end: classifies bytes, keeps row position and filter type
  pngu_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .bpp_raw     (bpp_r),
    .row_len_raw (row_len_r),
    .push_valid  (push_valid),
    .push_item   (push_item),
    .push_ready  (push_ready)
  );

  // decouples the front from back-end stalls
  pngu_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  // back end: line store read, prediction, result register
  pngu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire
